// ===== rtl/core/psem_pkg.sv =====
// shared types, constants and result codes of the priority counting semaphore
`default_nettype none
package psem_pkg;

  localparam int MAX_WAITERS_DEF = 32;
  localparam int MAX_RESULTS = 32;
  localparam int COUNT_W = 16;
  localparam int ID_W = 5;
  localparam int PRIO_W = 8;
  localparam int NUM_W = 8;
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_GRANTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEND_DONE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL = 3'd4;

  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } psem_entry_t;

  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } psem_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/priority_counting_semaphore.sv =====
// top level: request control, unit counter, result register and the chain of queue cells
//
// Requests enter on s_axis_*: tuser carries op (0 take, 1 send), tdata carries
// task_id, priority_req and send_num. Results leave on m_axis_*: tuser carries
// kind, tdata carries result_task and count_after, tlast marks the final result
// of a request. cfg_wen with cfg_wdata loads the unit count and empties the queue;
// write it only while no request is in progress.
// One request is handled at a time. A take passes through the EXEC state and loads
// its result there once the result register is free. A send of zero goes from EXEC
// back to idle with no result; any other send adds the units it does not hand to
// waiters to the count in the ADD state, then loads either one SEND_DONE result or
// one WOKEN result per woken waiter (at most MAX_RESULTS), one result per cycle
// while the receiver takes them. The queue is a row of MAX_WAITERS cells: an insert
// places the new waiter by priority; a wake shifts the row one place to the head.
// The next request is taken the cycle after the final result is registered, even
// while that result still waits. A stalled receiver holds the result register and
// pauses the wake run. Reset clears the count and the queue and drops any result.
`default_nettype none
module priority_counting_semaphore
  import psem_pkg::*;
#(
  parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // task_id, priority_req, send_num, zero pad
  input  wire logic        s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // result_task, count_after, zero pad
  output logic [2:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast
);

  localparam int TW = $clog2(MAX_WAITERS + 1);
  localparam int CW = (TW > NUM_W) ? TW : NUM_W;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_WAKE = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               req_op;
  logic [ID_W-1:0]    req_id;
  logic [PRIO_W-1:0]  req_prio;
  logic [NUM_W-1:0]   req_num;
  logic [COUNT_W-1:0] count;
  logic [TW-1:0]      total;
  logic [RW-1:0]      wake_left;
  logic [NUM_W-1:0]   rest;

  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [ID_W-1:0]    out_task;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;
  logic               out_free;
  logic               out_load;

  psem_cmd_t          cmd;
  psem_entry_t        ents [MAX_WAITERS];
  logic               afters [MAX_WAITERS];

  logic [CW-1:0]      num_c;
  logic [CW-1:0]      tot_c;
  logic [CW-1:0]      min_c;
  logic [CW-1:0]      wake_c;
  logic [COUNT_W:0]   sum;

  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, out_count, out_task};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

  // wake count: min of units, waiters and the per-send limit
  assign num_c = CW'(req_num);
  assign tot_c = CW'(total);
  assign min_c = (num_c < tot_c) ? num_c : tot_c;
  assign wake_c = (min_c > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : min_c;
  assign sum = {1'b0, count} + (COUNT_W + 1)'(rest);

  always_comb begin
    cmd.ins = 1'b0;
    cmd.pop = 1'b0;
    cmd.id = req_id;
    cmd.prio = req_prio;
    out_load = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (req_op == OP_SEND) begin
          state_next = (req_num == '0) ? ST_IDLE : ST_ADD;
        end else if (out_free) begin
          state_next = ST_IDLE;
          out_load = 1'b1;
          cmd.ins = (count == '0) && (total != TW'(MAX_WAITERS));
        end
      end
      ST_ADD: begin
        state_next = (wake_left == '0) ? ST_DONE : ST_WAKE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
          out_load = 1'b1;
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          cmd.pop = 1'b1;
          out_load = 1'b1;
          if (wake_left == RW'(1)) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        count <= COUNT_W'(cfg_wdata);
        total <= '0;
      end else begin
        unique case (state)
          ST_EXEC: begin
            if (req_op == OP_TAKE && out_free) begin
              if (count != '0) begin
                count <= count - COUNT_W'(1);
              end else if (total != TW'(MAX_WAITERS)) begin
                total <= total + TW'(1);
              end
            end
          end
          ST_ADD: begin
            count <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
          end
          ST_WAKE: begin
            if (out_free) begin
              total <= total - TW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_op <= s_axis_tuser;
      req_id <= s_axis_tdata[4:0];
      req_prio <= s_axis_tdata[12:5];
      req_num <= s_axis_tdata[20:13];
    end
    if (state == ST_EXEC) begin
      wake_left <= wake_c[RW-1:0];
      rest <= req_num - wake_c[NUM_W-1:0];
    end
    if (state == ST_WAKE && out_free) begin
      wake_left <= wake_left - RW'(1);
    end
    unique case (state)
      ST_EXEC: begin
        if (req_op == OP_TAKE && out_free) begin
          out_task <= req_id;
          out_last <= 1'b1;
          if (count != '0) begin
            out_kind <= KIND_GRANTED;
            out_count <= count - COUNT_W'(1);
          end else if (total != TW'(MAX_WAITERS)) begin
            out_kind <= KIND_QUEUED;
            out_count <= count;
          end else begin
            out_kind <= KIND_FULL;
            out_count <= count;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_kind <= KIND_SEND_DONE;
          out_task <= '0;
          out_count <= count;
          out_last <= 1'b1;
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          out_kind <= KIND_WOKEN;
          out_task <= ents[0].id;
          out_count <= count;
          out_last <= (wake_left == RW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    psem_cell #(
      .IDX(i),
      .TW (TW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .total     (total),
      .prev_ent  ((i == 0) ? ents[0] : ents[(i == 0) ? 0 : i - 1]),
      .prev_after((i == 0) ? 1'b0 : afters[(i == 0) ? 0 : i - 1]),
      .next_ent  ((i == MAX_WAITERS - 1) ? ents[i] : ents[(i == MAX_WAITERS - 1) ? i : i + 1]),
      .ent       (ents[i]),
      .after     (afters[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/psem_cell.sv =====
// one wait queue slot: sorted insert from its upper neighbour, pop from its lower neighbour
`default_nettype none
module psem_cell
  import psem_pkg::*;
#(
  parameter int IDX = 0,
  parameter int TW = 6
) (
  input  wire logic        clk,
  input  wire psem_cmd_t   cmd,
  input  wire logic [TW-1:0] total,
  input  wire psem_entry_t prev_ent,
  input  wire logic        prev_after,
  input  wire psem_entry_t next_ent,
  output psem_entry_t      ent,
  output logic             after
);

  psem_entry_t new_ent;

  // slot lies behind the insert point: past the tail or holds a lower priority
  assign after = (TW'(IDX) >= total) || (ent.prio < cmd.prio);
  assign new_ent = '{id: cmd.id, prio: cmd.prio};

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      ent <= next_ent;
    end else if (cmd.ins && after) begin
      ent <= prev_after ? prev_ent : new_ent;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/psem_check.sv =====
// port checker of the priority counting semaphore and its bind
`default_nettype none
module psem_check
  import psem_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one request at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // no new request while a wake run is unfinished
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during wake run");

  // only wakes come in runs
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_WOKEN |-> m_axis_tlast)
    else $error("single result without last");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind priority_counting_semaphore psem_check u_psem_check (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
